/* design/rgc_pkg.sv */
// ----------------------------------------------------------------------------
// rgc_pkg
// Shared types and constants for the readability grade counter.
// ----------------------------------------------------------------------------
package rgc_pkg;

    // Coleman-Liau weights scaled to integers: 588L - 2960S - 1580W over 100W
    localparam int C_LETTER = 588;
    localparam int C_SENT   = 2960;
    localparam int C_WORD   = 1580;
    localparam int C_DEN    = 100;

    localparam logic [7:0] CH_PERIOD = 8'h2E;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_QUEST  = 8'h3F;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;

    localparam int GRADE_W       = 22;
    localparam int OUT_W         = 16;
    localparam int GRADE_POS_MAX = 2097151;
    localparam int GRADE_NEG_MAG = 2097152;

    localparam logic [1:0] BAND_LOW  = 2'd0;
    localparam logic [1:0] BAND_MID  = 2'd1;
    localparam logic [1:0] BAND_HIGH = 2'd2;

    localparam int TDATA_IN_W  = 8;
    localparam int TDATA_OUT_W = 72;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_PREP,
        ST_DIV,
        ST_DONE
    } grade_state_t;

    typedef struct packed {
        logic [OUT_W-1:0]          sentence_total;
        logic [OUT_W-1:0]          word_total;
        logic [OUT_W-1:0]          letter_total;
        logic [1:0]                grade_band;
        logic signed [GRADE_W-1:0] grade;
    } grade_result_t;

endpackage

/* design/readability_grade_counter.sv */
// ----------------------------------------------------------------------------
// readability_grade_counter
// Counts letters, words and sentence marks of a byte stream and reports
// the Coleman-Liau grade, its band and the counts when a text ends.
//
//   channel | direction | tdata (low bit up)                         | tlast
//   s_      | in        | char_code[7:0]                            | last_char
//   m_      | out       | grade[21:0] grade_band[23:22]             | -
//           |           | letter_total[39:24] word_total[55:40]     |
//           |           | sentence_total[71:56]                     |
//
// Text bytes are accepted back to back while s_tready is high. After the
// byte with s_tlast, s_tready stays low while the grade divider runs one
// quotient bit per cycle and while the result waits for the output register.
// The output register holds one result, so counting of the next text starts
// while that result is still waiting on m_tready.
// aresetn is synchronous and clears all counts and the sequencer.
// ----------------------------------------------------------------------------
module readability_grade_counter
    import rgc_pkg::*;
#(
    parameter int COUNT_BITS = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [TDATA_IN_W-1:0]  s_tdata,   // char_code[7:0]
    input  logic                   s_tlast,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [TDATA_OUT_W-1:0] m_tdata    // grade, grade_band, letter_total,
                                              // word_total, sentence_total
);

    logic                  take, text_done;
    logic [COUNT_BITS-1:0] fin_letters, fin_words, fin_sents;
    logic                  seq_idle, res_valid, res_ready;
    grade_result_t         res;

    logic                   m_tvalid_reg, m_tvalid_next;
    logic [TDATA_OUT_W-1:0] m_tdata_reg, m_tdata_next;

    assign s_tready  = seq_idle;
    assign take      = s_tvalid && s_tready;
    assign res_ready = !m_tvalid_reg || m_tready;

    rgc_char_counter #(
        .COUNT_BITS (COUNT_BITS)
    ) u_counter (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .take        (take),
        .char_code   (s_tdata[7:0]),
        .last_char   (s_tlast),
        .text_done   (text_done),
        .fin_letters (fin_letters),
        .fin_words   (fin_words),
        .fin_sents   (fin_sents)
    );

    rgc_grade_seq #(
        .COUNT_BITS (COUNT_BITS)
    ) u_grade (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (text_done),
        .in_letters (fin_letters),
        .in_words   (fin_words),
        .in_sents   (fin_sents),
        .idle       (seq_idle),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (res_valid && res_ready) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = TDATA_OUT_W'(res);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

/* design/rgc_char_counter.sv */
// ----------------------------------------------------------------------------
// rgc_char_counter
// Classifies each text byte and keeps saturating letter, word and sentence
// counts. Presents the final counts on the byte that ends the text.
// ----------------------------------------------------------------------------
module rgc_char_counter
    import rgc_pkg::*;
#(
    parameter int COUNT_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  take,
    input  logic [7:0]            char_code,
    input  logic                  last_char,
    output logic                  text_done,
    output logic [COUNT_BITS-1:0] fin_letters,
    output logic [COUNT_BITS-1:0] fin_words,
    output logic [COUNT_BITS-1:0] fin_sents
);

    logic [COUNT_BITS-1:0] letters_reg, letters_next;
    logic [COUNT_BITS-1:0] words_reg, words_next;
    logic [COUNT_BITS-1:0] sents_reg, sents_next;
    logic                  in_word_reg, in_word_next;

    logic                  is_letter, is_mark, is_ws;
    logic [COUNT_BITS-1:0] words_step;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        sat_inc = (&v) ? v : v + COUNT_BITS'(1);
    endfunction

    always_comb begin
        is_letter = ((char_code >= CH_UPPER_A) && (char_code <= CH_UPPER_Z))
                 || ((char_code >= CH_LOWER_A) && (char_code <= CH_LOWER_Z));
        is_mark   = (char_code == CH_PERIOD) || (char_code == CH_BANG)
                 || (char_code == CH_QUEST);
        is_ws     = (char_code == CH_SPACE)
                 || ((char_code >= CH_TAB) && (char_code <= CH_CR));

        fin_letters  = is_letter ? sat_inc(letters_reg) : letters_reg;
        fin_sents    = is_mark ? sat_inc(sents_reg) : sents_reg;
        words_step   = (is_ws && in_word_reg) ? sat_inc(words_reg) : words_reg;
        // close a word still open at the end of the text
        fin_words    = !is_ws ? sat_inc(words_step) : words_step;
        text_done    = take && last_char;

        letters_next = letters_reg;
        words_next   = words_reg;
        sents_next   = sents_reg;
        in_word_next = in_word_reg;
        if (take) begin
            if (last_char) begin
                letters_next = '0;
                words_next   = '0;
                sents_next   = '0;
                in_word_next = 1'b0;
            end else begin
                letters_next = fin_letters;
                words_next   = words_step;
                sents_next   = fin_sents;
                in_word_next = !is_ws;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            letters_reg <= '0;
            words_reg   <= '0;
            sents_reg   <= '0;
            in_word_reg <= 1'b0;
        end else begin
            letters_reg <= letters_next;
            words_reg   <= words_next;
            sents_reg   <= sents_next;
            in_word_reg <= in_word_next;
        end
    end

endmodule

/* design/rgc_grade_seq.sv */
// ----------------------------------------------------------------------------
// rgc_grade_seq
// Sequencer around one shift-subtract unit: forms the Coleman-Liau
// numerator and denominator, adds the rounding offset, divides one quotient
// bit per cycle, then saturates and bands the grade.
// ----------------------------------------------------------------------------
module rgc_grade_seq
    import rgc_pkg::*;
#(
    parameter int COUNT_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [COUNT_BITS-1:0] in_letters,
    input  logic [COUNT_BITS-1:0] in_words,
    input  logic [COUNT_BITS-1:0] in_sents,
    output logic                  idle,
    output logic                  res_valid,
    input  logic                  res_ready,
    output grade_result_t         res
);

    localparam int PL_W  = COUNT_BITS + 10;
    localparam int PS_W  = COUNT_BITS + 12;
    localparam int PW_W  = COUNT_BITS + 11;
    localparam int DEN_W = COUNT_BITS + 7;
    localparam int NUM_W = COUNT_BITS + 14;
    localparam int MAG_W = COUNT_BITS + 13;
    localparam int DIV_W = COUNT_BITS + 15;
    localparam int DSR_W = COUNT_BITS + 8;
    localparam int CNT_W = $clog2(DIV_W);

    grade_state_t state_reg, state_next;

    logic [COUNT_BITS-1:0] l_reg, w_reg, s_reg;
    logic [PL_W-1:0]       pl_reg;
    logic [PS_W-1:0]       ps_reg;
    logic [PW_W-1:0]       pw_reg;
    logic [DEN_W-1:0]      den_reg;
    logic [MAG_W-1:0]      mag_reg;
    logic                  neg_reg;
    logic [DIV_W-1:0]      quot_reg;
    logic [DSR_W-1:0]      rem_reg;
    logic [DSR_W-1:0]      dsr_reg;
    logic [CNT_W-1:0]      cnt_reg;

    logic signed [NUM_W-1:0] num;
    logic [DSR_W:0]          shifted, diff;
    logic                    fits;
    logic [COUNT_BITS-1:0]   s_forced;
    logic signed [GRADE_W-1:0] grade;
    logic [OUT_W-1:0]        cap_l, cap_w, cap_s;

    // shift-subtract unit of the grade divider, numerator and sentence count
    always_comb begin
        shifted = {rem_reg, quot_reg[DIV_W-1]};
        fits    = shifted >= {1'b0, dsr_reg};
        diff    = shifted - {1'b0, dsr_reg};
        num     = NUM_W'(pl_reg) - NUM_W'(ps_reg) - NUM_W'(pw_reg);
        s_forced = ((in_words != '0) && (in_sents == '0)) ? COUNT_BITS'(1) : in_sents;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (start) state_next = ST_MUL;
            ST_MUL:  state_next = ST_SUM;
            ST_SUM:  state_next = ST_PREP;
            ST_PREP: state_next = ST_DIV;
            ST_DIV:  if (cnt_reg == '0) state_next = ST_DONE;
            ST_DONE: if (res_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
        idle      = (state_reg == ST_IDLE);
        res_valid = (state_reg == ST_DONE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                l_reg <= in_letters;
                w_reg <= in_words;
                s_reg <= s_forced;
            end
            ST_MUL: begin
                pl_reg  <= PL_W'(l_reg) * PL_W'(C_LETTER);
                ps_reg  <= PS_W'(s_reg) * PS_W'(C_SENT);
                pw_reg  <= PW_W'(w_reg) * PW_W'(C_WORD);
                den_reg <= DEN_W'(w_reg) * DEN_W'(C_DEN);
            end
            ST_SUM: begin
                neg_reg <= num[NUM_W-1];
                mag_reg <= num[NUM_W-1] ? MAG_W'(-num) : MAG_W'(num);
            end
            ST_PREP: begin
                // round half away from zero: (2|n| + d) / (2d)
                quot_reg <= DIV_W'({mag_reg, 1'b0}) + DIV_W'(den_reg);
                dsr_reg  <= {den_reg, 1'b0};
                rem_reg  <= '0;
                cnt_reg  <= CNT_W'(DIV_W - 1);
            end
            ST_DIV: begin
                rem_reg  <= fits ? diff[DSR_W-1:0] : shifted[DSR_W-1:0];
                quot_reg <= {quot_reg[DIV_W-2:0], fits};
                cnt_reg  <= cnt_reg - CNT_W'(1);
            end
            default: ;
        endcase
    end

    generate
        if (COUNT_BITS > OUT_W) begin : g_cap
            assign cap_l = (|l_reg[COUNT_BITS-1:OUT_W]) ? '1 : l_reg[OUT_W-1:0];
            assign cap_w = (|w_reg[COUNT_BITS-1:OUT_W]) ? '1 : w_reg[OUT_W-1:0];
            assign cap_s = (|s_reg[COUNT_BITS-1:OUT_W]) ? '1 : s_reg[OUT_W-1:0];
        end else begin : g_nocap
            assign cap_l = OUT_W'(l_reg);
            assign cap_w = OUT_W'(w_reg);
            assign cap_s = OUT_W'(s_reg);
        end
    endgenerate

    always_comb begin
        if (w_reg == '0) begin
            grade = '0;
        end else if (neg_reg) begin
            if (quot_reg > DIV_W'(GRADE_NEG_MAG)) begin
                grade = GRADE_W'(-GRADE_NEG_MAG);
            end else begin
                grade = -$signed(quot_reg[GRADE_W-1:0]);
            end
        end else begin
            if (quot_reg > DIV_W'(GRADE_POS_MAX)) begin
                grade = GRADE_W'(GRADE_POS_MAX);
            end else begin
                grade = $signed(quot_reg[GRADE_W-1:0]);
            end
        end

        res.grade          = grade;
        res.letter_total   = cap_l;
        res.word_total     = cap_w;
        res.sentence_total = cap_s;
        if (grade < GRADE_W'(1)) begin
            res.grade_band = BAND_LOW;
        end else if (grade >= GRADE_W'(16)) begin
            res.grade_band = BAND_HIGH;
        end else begin
            res.grade_band = BAND_MID;
        end
    end

endmodule
